// ----- rtl/core/csm_pkg.sv -----
// Shared types and constants of the collinear segment merger.
// Depends on nothing; every other file in rtl/core imports it.
package csm_pkg;

    localparam int COORD_BITS = 24;
    localparam int KIND_BITS  = 8;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int DOT_BITS   = PROD_BITS + 2;

    // Result queue: up to two results enter per cycle, one leaves.
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int LVL_BITS    = PTR_BITS + 1;
    localparam int PUSH_BITS   = 2;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] start_z;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
        logic signed [COORD_BITS-1:0] end_z;
        logic        [KIND_BITS-1:0]  kind_in;
        logic                         final_in;
    } seg_in_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_start_x;
        logic signed [COORD_BITS-1:0] out_start_y;
        logic signed [COORD_BITS-1:0] out_start_z;
        logic signed [COORD_BITS-1:0] out_end_x;
        logic signed [COORD_BITS-1:0] out_end_y;
        logic signed [COORD_BITS-1:0] out_end_z;
        logic        [KIND_BITS-1:0]  kind_out;
        logic                         final_out;
    } seg_out_t;

    typedef struct packed {
        logic signed [DIFF_BITS-1:0] x;
        logic signed [DIFF_BITS-1:0] y;
        logic signed [DIFF_BITS-1:0] z;
    } vec_t;

    // First pipeline stage: segment, its direction, the previous direction, the open flag
    typedef struct packed {
        seg_in_t seg;
        vec_t    dir;
        vec_t    prev_dir;
        logic    open;
    } stage1_t;

    // Second pipeline stage: segment, open flag and the products against the previous direction
    typedef struct packed {
        seg_in_t                     seg;
        logic                        open;
        logic signed [PROD_BITS-1:0] yz;
        logic signed [PROD_BITS-1:0] zy;
        logic signed [PROD_BITS-1:0] zx;
        logic signed [PROD_BITS-1:0] xz;
        logic signed [PROD_BITS-1:0] xy;
        logic signed [PROD_BITS-1:0] yx;
        logic signed [PROD_BITS-1:0] dot_x;
        logic signed [PROD_BITS-1:0] dot_y;
        logic signed [PROD_BITS-1:0] dot_z;
    } stage2_t;

    // Results written to the queue in one cycle, in order
    typedef struct packed {
        logic [PUSH_BITS-1:0] num;
        seg_out_t             first;
        seg_out_t             second;
    } push_t;

endpackage

// ----- rtl/core/csm_front.sv -----
// Input register of the merger: takes a segment, forms its direction vector
// and pairs it with the direction of the segment before. Uses csm_pkg.
module csm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             seg_valid,
    input  csm_pkg::seg_in_t seg,
    output logic             s1_valid,
    output csm_pkg::stage1_t s1
);
    import csm_pkg::*;

    logic    s1_valid_reg;
    stage1_t s1_reg;
    vec_t    last_dir_reg;
    logic    open_reg;
    vec_t    dir;

    // Direction is end minus start, one bit wider
    always_comb
    begin
        dir.x = DIFF_BITS'({seg.end_x[COORD_BITS-1], seg.end_x})
              - DIFF_BITS'({seg.start_x[COORD_BITS-1], seg.start_x});
        dir.y = DIFF_BITS'({seg.end_y[COORD_BITS-1], seg.end_y})
              - DIFF_BITS'({seg.start_y[COORD_BITS-1], seg.start_y});
        dir.z = DIFF_BITS'({seg.end_z[COORD_BITS-1], seg.end_z})
              - DIFF_BITS'({seg.start_z[COORD_BITS-1], seg.start_z});
    end

    // Track whether the list is open, i.e. a run is held when this segment arrives
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            open_reg     <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= seg_valid;
            if (seg_valid)
            begin
                open_reg <= ~seg.final_in;
            end
        end
    end

    // Load the transfer together with the previous direction
    always_ff @(posedge clk)
    begin
        if (adv && seg_valid)
        begin
            s1_reg.seg      <= seg;
            s1_reg.dir      <= dir;
            s1_reg.prev_dir <= last_dir_reg;
            s1_reg.open     <= open_reg;
            last_dir_reg    <= dir;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1       = s1_reg;

endmodule

// ----- rtl/core/csm_product.sv -----
// Product stage: multiplies the segment direction against the previous
// segment's direction for the cross and dot tests. Uses csm_pkg.
module csm_product (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             s1_valid,
    input  csm_pkg::stage1_t s1,
    output logic             s2_valid,
    output csm_pkg::stage2_t s2
);
    import csm_pkg::*;

    logic    s2_valid_reg;
    stage2_t s2_reg;
    stage2_t s2_next;

    // Nine parallel products, each 25 by 25 bits
    always_comb
    begin
        s2_next.seg   = s1.seg;
        s2_next.open  = s1.open;
        s2_next.yz    = $signed(s1.prev_dir.y) * $signed(s1.dir.z);
        s2_next.zy    = $signed(s1.prev_dir.z) * $signed(s1.dir.y);
        s2_next.zx    = $signed(s1.prev_dir.z) * $signed(s1.dir.x);
        s2_next.xz    = $signed(s1.prev_dir.x) * $signed(s1.dir.z);
        s2_next.xy    = $signed(s1.prev_dir.x) * $signed(s1.dir.y);
        s2_next.yx    = $signed(s1.prev_dir.y) * $signed(s1.dir.x);
        s2_next.dot_x = $signed(s1.prev_dir.x) * $signed(s1.dir.x);
        s2_next.dot_y = $signed(s1.prev_dir.y) * $signed(s1.dir.y);
        s2_next.dot_z = $signed(s1.prev_dir.z) * $signed(s1.dir.z);
    end

    // Advance the stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    // Hold the products
    always_ff @(posedge clk)
    begin
        if (adv && s1_valid)
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2       = s2_reg;

endmodule

// ----- rtl/core/csm_tracker.sv -----
// Run tracker: decides merge or new run, keeps the held segment and hands
// zero, one or two results to the result queue. Uses csm_pkg.
module csm_tracker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             s2_valid,
    input  csm_pkg::stage2_t s2,
    output csm_pkg::push_t   push
);
    import csm_pkg::*;

    logic                        holding_reg;
    seg_out_t                    held_reg;
    seg_out_t                    held_next;
    logic signed [DOT_BITS-1:0]  dot;
    logic                        parallel;
    logic                        merge;
    logic                        emit_old;
    logic                        step;

    // Same direction as the previous segment; a merged run shares its direction
    always_comb
    begin
        dot = DOT_BITS'(s2.dot_x) + DOT_BITS'(s2.dot_y) + DOT_BITS'(s2.dot_z);
        parallel = (s2.yz == s2.zy) && (s2.zx == s2.xz) && (s2.xy == s2.yx);
        merge    = s2.open && parallel && !dot[DOT_BITS-1] && (dot != '0);
        step     = adv && s2_valid;
        emit_old = holding_reg && !merge;
    end

    // Extend the held run or start a new one
    always_comb
    begin
        held_next = held_reg;
        held_next.out_end_x = s2.seg.end_x;
        held_next.out_end_y = s2.seg.end_y;
        held_next.out_end_z = s2.seg.end_z;
        held_next.final_out = 1'b0;
        if (!merge)
        begin
            held_next.out_start_x = s2.seg.start_x;
            held_next.out_start_y = s2.seg.start_y;
            held_next.out_start_z = s2.seg.start_z;
            held_next.kind_out    = s2.seg.kind_in;
        end
    end

    // Order results: closed run first, then the flushed run of a last segment
    always_comb
    begin
        push.num    = '0;
        push.first  = held_reg;
        push.second = held_next;
        push.first.final_out  = 1'b0;
        push.second.final_out = 1'b1;
        if (step)
        begin
            push.num = PUSH_BITS'(emit_old) + PUSH_BITS'(s2.seg.final_in);
            if (!emit_old)
            begin
                push.first = push.second;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            holding_reg <= 1'b0;
        end
        else if (step)
        begin
            holding_reg <= ~s2.seg.final_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            held_reg <= held_next;
        end
    end

endmodule

// ----- rtl/core/csm_queue.sv -----
// Result queue: takes up to two results per cycle, gives one per transfer.
// Uses csm_pkg.
module csm_queue (
    input  logic                           clk,
    input  logic                           rst_n,
    input  csm_pkg::push_t                 push,
    input  logic                           res_stall,
    output logic                           res_valid,
    output csm_pkg::seg_out_t              res,
    output logic [csm_pkg::LVL_BITS-1:0]   level
);
    import csm_pkg::*;

    seg_out_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [LVL_BITS-1:0] level_reg;
    logic [PTR_BITS-1:0] wr_ptr_second;
    logic                pop;

    assign wr_ptr_second = PTR_BITS'(wr_ptr_reg + 1'b1);
    assign pop           = res_valid && !res_stall;

    // Write one or two entries
    always_ff @(posedge clk)
    begin
        if (push.num != '0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.num == PUSH_BITS'(2))
        begin
            entry_reg[wr_ptr_second] <= push.second;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= PTR_BITS'(wr_ptr_reg + push.num);
            if (pop)
            begin
                rd_ptr_reg <= PTR_BITS'(rd_ptr_reg + 1'b1);
            end
            level_reg <= level_reg + LVL_BITS'(push.num) - LVL_BITS'(pop);
        end
    end

    assign res_valid = (level_reg != '0);
    assign res       = entry_reg[rd_ptr_reg];
    assign level     = level_reg;

endmodule

// ----- rtl/core/collinear_segment_merger.sv -----
// Collinear segment merger, top level. The result that a segment closes
// or flushes passes the input, product and queue registers before it is offered.
// Throughput: one segment per cycle while seg_stall is low; seg_stall rises while more
// than two results wait in the four-entry result queue, whose single read port sets the rate.
// Reset (rst_n, asynchronous): nothing held, pipeline and queue empty.
// Uses csm_pkg, csm_front, csm_product, csm_tracker, csm_queue.
module collinear_segment_merger (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seg_valid,
    output logic              seg_stall,
    input  csm_pkg::seg_in_t  seg,
    output logic              res_valid,
    input  logic              res_stall,
    output csm_pkg::seg_out_t res
);
    import csm_pkg::*;

    logic                adv;
    logic                s1_valid;
    stage1_t             s1;
    logic                s2_valid;
    stage2_t             s2;
    push_t               push;
    logic [LVL_BITS-1:0] level;

    // Move the whole pipeline while the queue has room for two results
    assign adv       = (level <= LVL_BITS'(QUEUE_DEPTH - 2));
    assign seg_stall = ~adv;

    csm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .seg_valid(seg_valid),
        .seg      (seg),
        .s1_valid (s1_valid),
        .s1       (s1)
    );

    csm_product u_product (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .s1_valid(s1_valid),
        .s1      (s1),
        .s2_valid(s2_valid),
        .s2      (s2)
    );

    csm_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .s2_valid(s2_valid),
        .s2      (s2),
        .push    (push)
    );

    csm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .res_stall(res_stall),
        .res_valid(res_valid),
        .res      (res),
        .level    (level)
    );

    // Queue never overflows
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= LVL_BITS'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // Results enter only while the pipeline advances
    a_push_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != '0) |-> !seg_stall)
        else $error("result pushed while pipeline held");

    // A pair is a closed run followed by the flush of a last segment
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num == PUSH_BITS'(2)) |-> (push.second.final_out && !push.first.final_out))
        else $error("result pair out of order");

endmodule
